// ===== rtl/evt_pkg.sv =====
// Shared types, codes and elaboration-time curve helpers for the eased value tween.
package evt_pkg;

    // Q1.16 one, and Q30 constants for building the curve tables
    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;

    // Quotient bits produced by the progress divider
    localparam int DIV_STEPS = 16;

    // Command codes
    localparam logic [1:0] FUNC_TICK    = 2'd0;
    localparam logic [1:0] FUNC_ANIMATE = 2'd1;
    localparam logic [1:0] FUNC_RESET   = 2'd2;

    // Easing modes
    localparam logic [2:0] MODE_IMMEDIATE = 3'd0;
    localparam logic [2:0] MODE_LINEAR    = 3'd1;
    localparam logic [2:0] MODE_EASE_IN   = 3'd2;
    localparam logic [2:0] MODE_EASE_OUT  = 3'd3;
    localparam logic [2:0] MODE_SINE      = 3'd4;

    // Register indexes
    localparam logic [1:0] CFG_EASING_MODE = 2'd0;
    localparam logic [1:0] CFG_DURATION    = 2'd1;
    localparam logic [1:0] CFG_DELAY       = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic prog;
        logic ease1;
        logic ease2;
        logic ease3;
        logic blend;
        logic commit;
        logic out_load;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_div;
    } status_t;

    // Rounded integer square root
    function automatic logic [63:0] sqrt_round(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] rem;
        logic [63:0] bitv;
        r   = 64'd0;
        rem = v;
        for (int i = 0; i < 32; i++) begin
            bitv = 64'd1 << (62 - 2 * i);
            if (rem >= r + bitv) begin
                rem = rem - (r + bitv);
                r   = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
        end
        if (rem > r) begin
            r = r + 64'd1;
        end
        return r;
    endfunction

    // Cosine in Q30 over the first quadrant, Taylor series of nine terms
    function automatic logic [63:0] cos_q30(input logic [63:0] t);
        logic [63:0]        t2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [31:0]        n;
        t2   = (t * t) >> 30;
        term = ONE_Q30;
        sum  = $signed(ONE_Q30);
        for (int k = 1; k <= 8; k++) begin
            n    = 32'(k);
            term = ((term * t2) >> 30) / 64'((2 * k - 1) * (2 * k));
            if (n[0]) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = 64'sd0;
        end
        if (sum > $signed(ONE_Q30)) begin
            sum = $signed(ONE_Q30);
        end
        return 64'(sum);
    endfunction

endpackage

// ===== rtl/evt_ctrl.sv =====
// Sequencer for the eased value tween: steps one command through the datapath.
module evt_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  evt_pkg::status_t status,
    output evt_pkg::cmd_t   cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECODE = 4'd1;
    localparam logic [3:0] ST_DIV    = 4'd2;
    localparam logic [3:0] ST_PROG   = 4'd3;
    localparam logic [3:0] ST_EASE1  = 4'd4;
    localparam logic [3:0] ST_EASE2  = 4'd5;
    localparam logic [3:0] ST_EASE3  = 4'd6;
    localparam logic [3:0] ST_BLEND  = 4'd7;
    localparam logic [3:0] ST_COMMIT = 4'd8;
    localparam logic [3:0] ST_OUT    = 4'd9;

    localparam int CW = $clog2(evt_pkg::DIV_STEPS);
    localparam logic [CW-1:0] CNT_LAST = CW'(evt_pkg::DIV_STEPS - 1);

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (status.need_div) begin
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = ST_DIV;
                end else begin
                    state_next = ST_COMMIT;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_PROG;
                end
            end
            ST_PROG: begin
                cmd.prog   = 1'b1;
                state_next = ST_EASE1;
            end
            ST_EASE1: begin
                cmd.ease1  = 1'b1;
                state_next = ST_EASE2;
            end
            ST_EASE2: begin
                cmd.ease2  = 1'b1;
                state_next = ST_EASE3;
            end
            ST_EASE3: begin
                cmd.ease3  = 1'b1;
                state_next = ST_BLEND;
            end
            ST_BLEND: begin
                cmd.blend  = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // Hold until the output slot is free
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== rtl/evt_dp.sv =====
// Datapath for the eased value tween: registers, divider, curve tables and blend.
module evt_dp #(
    parameter int CURVE_ENTRIES = 256,
    parameter int VALUE_BITS    = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  evt_pkg::cmd_t     cmd,
    output evt_pkg::status_t  status,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic [1:0]        s_func,
    input  logic [15:0]       s_delta_ticks,
    input  logic signed [15:0] s_target,
    output logic signed [15:0] m_current_value,
    output logic [16:0]       m_progress_now,
    output logic              m_changed,
    output logic              m_arrived,
    output logic              m_started
);

    localparam int VB = VALUE_BITS;
    localparam int IW = $clog2(CURVE_ENTRIES + 1);
    localparam int PW = 16 + IW;

    // Curve tables, built at elaboration
    logic [16:0] eo_tab [0:CURVE_ENTRIES];
    logic [16:0] sn_tab [0:CURVE_ENTRIES];

    for (genvar k = 0; k <= CURVE_ENTRIES; k++) begin : g_rom
        localparam logic [63:0] SQ_ARG =
            (64'(CURVE_ENTRIES - k) << 32) / 64'(CURVE_ENTRIES);
        localparam logic [63:0] SQ = evt_pkg::sqrt_round(SQ_ARG);
        localparam int MIR = (2 * k <= CURVE_ENTRIES) ? k : CURVE_ENTRIES - k;
        localparam logic [63:0] ANG = (evt_pkg::PI_Q30 * 64'(MIR)) / 64'(CURVE_ENTRIES);
        localparam logic [63:0] CV = evt_pkg::cos_q30(ANG);
        localparam logic [63:0] HV = ((evt_pkg::ONE_Q30 - CV) + 64'd16384) >> 15;
        assign eo_tab[k] = (SQ > 64'd65536) ? 17'd0 : 17'(64'd65536 - SQ);
        assign sn_tab[k] = (2 * k <= CURVE_ENTRIES) ? 17'(HV) : 17'(64'd65536 - HV);
    end

    // Configuration
    logic [2:0]  mode_reg;
    logic [15:0] dur_reg;
    logic [15:0] dly_reg;

    // Architectural state
    logic signed [VB-1:0] value_reg;
    logic signed [VB-1:0] start_reg;
    logic signed [VB-1:0] goal_reg;
    logic [16:0]          prog_reg;
    logic [16:0]          del_el_reg;
    logic                 chg_reg;
    logic                 arr_reg;
    logic                 sta_reg;

    // Captured beat and working registers
    logic [1:0]           func_reg;
    logic [15:0]          delta_reg;
    logic signed [VB-1:0] tgt_reg;
    logic [15:0]          rem_reg;
    logic [15:0]          quo_reg;
    logic [17:0]          p_reg;
    logic [31:0]          sq_reg;
    logic [PW-1:0]        pos_reg;
    logic [16:0]          a_reg;
    logic                 up_reg;
    logic [32:0]          intp_reg;
    logic [16:0]          e_reg;
    logic signed [VB+18:0] prod_reg;

    // Target wrapped into the value width
    logic signed [VB+15:0] tgt_wide;
    assign tgt_wide = (VB + 16)'(s_target);

    // Decode the tick case
    logic delay_pending;
    logic big_step;
    assign delay_pending = ({1'b0, dly_reg} > del_el_reg);
    assign big_step      = (delta_reg >= dur_reg);
    assign status.need_div = (func_reg == evt_pkg::FUNC_TICK) &&
                             (mode_reg != evt_pkg::MODE_IMMEDIATE) &&
                             !delay_pending && !big_step;

    // Divider step
    logic [16:0] div_trial;
    assign div_trial = {rem_reg, 1'b0};

    // Table lookup
    logic [IW-1:0] idx0, idx1;
    logic [16:0]   tab_a, tab_b;
    assign idx0 = pos_reg[PW-1:16];
    assign idx1 = idx0 + 1'b1;
    always_comb begin
        if (mode_reg == evt_pkg::MODE_EASE_OUT) begin
            tab_a = eo_tab[idx0];
            tab_b = eo_tab[idx1];
        end else begin
            tab_a = sn_tab[idx0];
            tab_b = sn_tab[idx1];
        end
    end

    // Ease select
    logic [16:0] ease_val;
    logic [16:0] intp_rnd;
    assign intp_rnd = 17'((intp_reg + 33'd32768) >> 16);
    always_comb begin
        case (mode_reg)
            evt_pkg::MODE_EASE_IN: ease_val = 17'((33'(sq_reg) + 33'd32768) >> 16);
            evt_pkg::MODE_EASE_OUT,
            evt_pkg::MODE_SINE: ease_val = up_reg ? a_reg + intp_rnd : a_reg - intp_rnd;
            default:            ease_val = p_reg[16:0];
        endcase
    end

    // Blend result
    logic signed [VB:0]    diff;
    logic signed [VB+18:0] blend_q;
    logic signed [VB-1:0]  blend_val;
    assign diff      = (VB + 1)'(goal_reg) - (VB + 1)'(start_reg);
    assign blend_q   = prod_reg + (VB + 19)'(32768);
    assign blend_val = start_reg + VB'(blend_q >>> 16);

    // Value on the result port
    logic signed [VB+15:0] val_wide;
    assign val_wide = (VB + 16)'(value_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= evt_pkg::MODE_LINEAR;
            dur_reg    <= 16'd1000;
            dly_reg    <= 16'd0;
            value_reg  <= '0;
            start_reg  <= '0;
            goal_reg   <= '0;
            prog_reg   <= evt_pkg::ONE_Q16;
            del_el_reg <= '0;
            chg_reg    <= 1'b0;
            arr_reg    <= 1'b0;
            sta_reg    <= 1'b0;
        end else begin
            // Register writes
            if (cfg_we) begin
                unique case (cfg_index)
                    evt_pkg::CFG_EASING_MODE: mode_reg <= cfg_data[2:0];
                    evt_pkg::CFG_DURATION:    dur_reg  <= cfg_data;
                    evt_pkg::CFG_DELAY: begin
                        dly_reg    <= cfg_data;
                        del_el_reg <= '0;
                    end
                    default: ;
                endcase
            end
            // Apply the command
            if (cmd.commit) begin
                arr_reg <= 1'b0;
                sta_reg <= 1'b0;
                case (func_reg)
                    evt_pkg::FUNC_TICK: begin
                        if (mode_reg == evt_pkg::MODE_IMMEDIATE) begin
                            if (goal_reg != value_reg || prog_reg != evt_pkg::ONE_Q16) begin
                                value_reg <= goal_reg;
                                prog_reg  <= evt_pkg::ONE_Q16;
                                arr_reg   <= 1'b1;
                                chg_reg   <= 1'b1;
                            end else begin
                                chg_reg <= 1'b0;
                            end
                        end else if (delay_pending) begin
                            del_el_reg <= del_el_reg + 17'(delta_reg);
                            chg_reg    <= 1'b0;
                        end else if (big_step || p_reg >= 18'(evt_pkg::ONE_Q16)) begin
                            prog_reg <= evt_pkg::ONE_Q16;
                            if (value_reg != goal_reg) begin
                                value_reg <= goal_reg;
                                chg_reg   <= 1'b1;
                                arr_reg   <= 1'b1;
                            end else begin
                                chg_reg <= 1'b0;
                            end
                        end else begin
                            prog_reg  <= p_reg[16:0];
                            value_reg <= blend_val;
                            chg_reg   <= 1'b1;
                        end
                    end
                    evt_pkg::FUNC_ANIMATE: begin
                        if (goal_reg != tgt_reg) begin
                            start_reg  <= value_reg;
                            goal_reg   <= tgt_reg;
                            prog_reg   <= '0;
                            del_el_reg <= '0;
                            sta_reg    <= 1'b1;
                        end
                    end
                    evt_pkg::FUNC_RESET: begin
                        if (value_reg != tgt_reg) begin
                            chg_reg <= 1'b1;
                        end
                        value_reg  <= tgt_reg;
                        start_reg  <= tgt_reg;
                        goal_reg   <= tgt_reg;
                        prog_reg   <= evt_pkg::ONE_Q16;
                        del_el_reg <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Working registers, no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg  <= s_func;
            delta_reg <= s_delta_ticks;
            tgt_reg   <= tgt_wide[VB-1:0];
        end
        if (cmd.div_init) begin
            rem_reg <= delta_reg;
            quo_reg <= '0;
        end
        // One quotient bit per step
        if (cmd.div_step) begin
            if (div_trial >= {1'b0, dur_reg}) begin
                rem_reg <= 16'(div_trial - {1'b0, dur_reg});
                quo_reg <= {quo_reg[14:0], 1'b1};
            end else begin
                rem_reg <= div_trial[15:0];
                quo_reg <= {quo_reg[14:0], 1'b0};
            end
        end
        if (cmd.prog) begin
            p_reg <= 18'(prog_reg) + 18'(quo_reg);
        end
        if (cmd.ease1) begin
            sq_reg  <= 32'(p_reg[15:0]) * 32'(p_reg[15:0]);
            pos_reg <= PW'(p_reg[15:0]) * PW'(CURVE_ENTRIES);
        end
        if (cmd.ease2) begin
            a_reg  <= tab_a;
            up_reg <= (tab_b >= tab_a);
            if (tab_b >= tab_a) begin
                intp_reg <= 33'(tab_b - tab_a) * 33'(pos_reg[15:0]);
            end else begin
                intp_reg <= 33'(tab_a - tab_b) * 33'(pos_reg[15:0]);
            end
        end
        if (cmd.ease3) begin
            e_reg <= ease_val;
        end
        if (cmd.blend) begin
            prod_reg <= (VB + 19)'(diff) * (VB + 19)'($signed({1'b0, e_reg}));
        end
        // Output beat
        if (cmd.out_load) begin
            m_current_value <= val_wide[15:0];
            m_progress_now  <= prog_reg;
            m_changed       <= chg_reg;
            m_arrived       <= arr_reg;
            m_started       <= sta_reg;
        end
    end

endmodule

// ===== rtl/eased_value_tween_core.sv =====
// Top level of the eased value tween: controller, datapath and port wiring.
//
// Each command beat yields exactly one result beat. A tick past the delay whose
// step is shorter than the duration runs the full datapath: decode, then the
// restoring divider that forms delta over duration, then the progress add, the
// square and table position, the curve lookup with interpolation, the ease
// select and the blend multiply, each in its own state, then the commit.
// Other commands, and ticks that wait out the delay, whose step reaches the
// duration or that run in immediate mode, go from decode straight to the commit.
// One command is in flight at a time; a result held on the output does not stop
// the next command from being taken, but that command waits before loading its
// own result until the held one leaves. Register writes are accepted every cycle
// and must only be issued while idle.
module eased_value_tween_core #(
    parameter int CURVE_ENTRIES = 256,
    parameter int VALUE_BITS    = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic [15:0]        s_delta_ticks,
    input  logic signed [15:0] s_target,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_current_value,
    output logic [16:0]        m_progress_now,
    output logic               m_changed,
    output logic               m_arrived,
    output logic               m_started
);

    evt_pkg::cmd_t    cmd;
    evt_pkg::status_t status;

    assign cfg_ready = 1'b1;

    evt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    evt_dp #(
        .CURVE_ENTRIES (CURVE_ENTRIES),
        .VALUE_BITS    (VALUE_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_func          (s_func),
        .s_delta_ticks   (s_delta_ticks),
        .s_target        (s_target),
        .m_current_value (m_current_value),
        .m_progress_now  (m_progress_now),
        .m_changed       (m_changed),
        .m_arrived       (m_arrived),
        .m_started       (m_started)
    );

endmodule

// ===== tb/eased_value_tween_core_test.sv =====
// Self-checking testbench for the eased value tween core.
`timescale 1ns / 100ps

module eased_value_tween_core_test;

    localparam int CURVE_N   = 256;
    localparam int CYCLE_CAP = 2000000;

    // One command beat and one result beat
    typedef struct {
        logic [1:0]         func;
        logic [15:0]        delta;
        logic signed [15:0] target;
    } cmd_beat_t;

    typedef struct {
        logic signed [15:0] value;
        logic [16:0]        progress;
        logic               changed;
        logic               arrived;
        logic               started;
    } tween_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_func = '0;
    logic [15:0]        s_delta_ticks = '0;
    logic signed [15:0] s_target = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_current_value;
    logic [16:0]        m_progress_now;
    logic               m_changed;
    logic               m_arrived;
    logic               m_started;

    eased_value_tween_core dut (.*);

    always #2 aclk = ~aclk;

    // Tween state mirrored from the block
    logic [2:0]         mode_q;
    logic [15:0]        duration_q;
    logic [15:0]        delay_q;
    logic signed [15:0] value_q;
    logic signed [15:0] from_q;
    logic signed [15:0] goal_q;
    logic [16:0]        progress_q;
    logic [16:0]        waited_q;
    logic               changed_q;

    longint unsigned ease_out_curve [CURVE_N+1];
    longint unsigned sine_curve [CURVE_N+1];

    cmd_beat_t     pending_cmds [$];
    tween_result_t expected_results [$];
    int            mismatches = 0;
    int            cycles = 0;
    bit            hold_sender = 0;

    function automatic longint unsigned curve_at(bit sine, longint unsigned p);
        longint unsigned pos, idx, fr, a, b;
        pos = p * CURVE_N;
        idx = pos >> 16;
        fr  = pos & 16'hFFFF;
        if (idx >= CURVE_N) return 65536;
        a = sine ? sine_curve[idx] : ease_out_curve[idx];
        b = sine ? sine_curve[idx+1] : ease_out_curve[idx+1];
        if (b >= a) return a + (((b - a) * fr + 32768) >> 16);
        return a - (((a - b) * fr + 32768) >> 16);
    endfunction

    // Interpolate from start toward goal, rounding ties toward plus infinity
    function automatic logic signed [15:0] mix_value(longint a, longint b, longint e);
        longint q, r;
        q = (b - a) * e + 32768;
        if (q >= 0) r = q / 65536;
        else r = -((-q + 65535) / 65536);
        return 16'(a + r);
    endfunction

    function automatic tween_result_t apply_command(cmd_beat_t c);
        tween_result_t   res;
        longint unsigned inc, p, e;
        res.arrived = 0;
        res.started = 0;
        if (c.func == evt_pkg::FUNC_TICK) begin
            if (mode_q == evt_pkg::MODE_IMMEDIATE) begin
                if (goal_q != value_q || progress_q != evt_pkg::ONE_Q16) begin
                    value_q = goal_q;
                    progress_q = evt_pkg::ONE_Q16;
                    res.arrived = 1;
                    changed_q = 1;
                end else changed_q = 0;
            end else if (waited_q < {1'b0, delay_q}) begin
                waited_q = waited_q + c.delta;
                changed_q = 0;
            end else begin
                inc = (duration_q == 0) ? 65536 : ({48'd0, c.delta} << 16) / duration_q;
                p = progress_q + inc;
                if (p >= 65536) begin
                    progress_q = evt_pkg::ONE_Q16;
                    if (value_q != goal_q) begin
                        value_q = goal_q;
                        changed_q = 1;
                        res.arrived = 1;
                    end else changed_q = 0;
                end else begin
                    progress_q = 17'(p);
                    case (mode_q)
                        evt_pkg::MODE_EASE_IN:  e = (p * p + 32768) >> 16;
                        evt_pkg::MODE_EASE_OUT: e = curve_at(0, p);
                        evt_pkg::MODE_SINE:     e = curve_at(1, p);
                        default:                e = p;
                    endcase
                    value_q = mix_value(from_q, goal_q, e);
                    changed_q = 1;
                end
            end
        end else if (c.func == evt_pkg::FUNC_ANIMATE) begin
            if (goal_q != c.target) begin
                from_q = value_q;
                goal_q = c.target;
                progress_q = 0;
                waited_q = 0;
                res.started = 1;
            end
        end else if (c.func == evt_pkg::FUNC_RESET) begin
            if (value_q != c.target) changed_q = 1;
            value_q = c.target;
            from_q = c.target;
            goal_q = c.target;
            progress_q = evt_pkg::ONE_Q16;
            waited_q = 0;
        end
        res.value = value_q;
        res.progress = progress_q;
        res.changed = changed_q;
        return res;
    endfunction

    // Record the accepting edge for the driver
    bit took_beat = 0;
    always @(posedge aclk) begin
        took_beat <= aresetn && s_valid && s_ready;
    end

    // Driver: bursts of beats with random gaps, changes on falling edge
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (took_beat) begin
                expected_results.push_back(apply_command(pending_cmds.pop_front()));
            end
            if (!s_valid || took_beat) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (pending_cmds.size() > 0 && !hold_sender) begin
                    s_valid <= 1'b1;
                    s_func <= pending_cmds[0].func;
                    s_delta_ticks <= pending_cmds[0].delta;
                    s_target <= pending_cmds[0].target;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    end else burst_left <= burst_left - 1;
                end else s_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern: phases of always-ready and random stalls
    int stall_phase = 0;
    always @(negedge aclk) begin
        stall_phase <= (stall_phase + 1) % 600;
        if (stall_phase < 200) m_ready <= 1'b1;
        else if (stall_phase < 400) m_ready <= ($urandom_range(0, 3) != 0);
        else m_ready <= ($urandom_range(0, 7) == 0);
    end

    // Monitor: compare each result beat against the oldest prediction
    always @(posedge aclk) begin
        tween_result_t exp_r;
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected result beat value=%0d", m_current_value);
            end else begin
                exp_r = expected_results.pop_front();
                if (exp_r.value !== m_current_value || exp_r.progress !== m_progress_now ||
                    exp_r.changed !== m_changed || exp_r.arrived !== m_arrived ||
                    exp_r.started !== m_started) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) begin
                        $display("mismatch expected v=%0d p=%0d c%0b a%0b s%0b",
                                 exp_r.value, exp_r.progress, exp_r.changed,
                                 exp_r.arrived, exp_r.started);
                        $display("         actual   v=%0d p=%0d c%0b a%0b s%0b",
                                 m_current_value, m_progress_now, m_changed,
                                 m_arrived, m_started);
                    end
                end
            end
        end
        if (cycles > CYCLE_CAP) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic cmd_beat_t make_cmd(logic [1:0] f, logic [15:0] d, logic [15:0] t);
        cmd_beat_t c;
        c.func = f;
        c.delta = d;
        c.target = t;
        return c;
    endfunction

    // Write one register while idle; the mirror follows at the same beat
    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            evt_pkg::CFG_EASING_MODE: mode_q = data[2:0];
            evt_pkg::CFG_DURATION:    duration_q = data;
            evt_pkg::CFG_DELAY: begin
                delay_q = data;
                waited_q = 0;
            end
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until all queued beats are taken and all results returned
    task automatic drain();
        while (pending_cmds.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic random_cmds(int n, int max_delta);
        int k;
        for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
                0, 1: pending_cmds.push_back(make_cmd(evt_pkg::FUNC_ANIMATE, 16'($urandom),
                                                      16'($urandom)));
                2:    pending_cmds.push_back(make_cmd(evt_pkg::FUNC_RESET, 16'($urandom),
                                                      16'($urandom)));
                3:    pending_cmds.push_back(make_cmd(2'd3, 16'($urandom), 16'($urandom)));
                4:    pending_cmds.push_back(make_cmd(evt_pkg::FUNC_TICK, 16'($urandom),
                                                      16'($urandom)));
                default: pending_cmds.push_back(make_cmd(evt_pkg::FUNC_TICK,
                                                      16'($urandom_range(0, max_delta)),
                                                      16'($urandom)));
            endcase
        end
    endtask

    initial begin
        longint unsigned s, c;
        int k, ph;
        // Build the easing curves
        for (k = 0; k <= CURVE_N; k++) begin
            s = evt_pkg::sqrt_round((64'(CURVE_N - k) << 32) / CURVE_N);
            ease_out_curve[k] = 65536 - ((s > 65536) ? 65536 : s);
            if (2 * k <= CURVE_N) begin
                c = evt_pkg::cos_q30((evt_pkg::PI_Q30 * k) / CURVE_N);
                sine_curve[k] = ((evt_pkg::ONE_Q30 - c) + 16384) >> 15;
            end
        end
        for (k = 0; k <= CURVE_N; k++)
            if (2 * k > CURVE_N) sine_curve[k] = 65536 - sine_curve[CURVE_N - k];
        mode_q = evt_pkg::MODE_LINEAR;
        duration_q = 16'd1000;
        delay_q = 16'd0;
        value_q = 0;
        from_q = 0;
        goal_q = 0;
        progress_q = evt_pkg::ONE_Q16;
        waited_q = 0;
        changed_q = 0;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, every command, animate to same goal, no-op code
        pending_cmds.push_back(make_cmd(evt_pkg::FUNC_TICK, 16'd0, 16'sd0));
        pending_cmds.push_back(make_cmd(evt_pkg::FUNC_ANIMATE, 16'hFFFF, 16'sh7FFF));
        pending_cmds.push_back(make_cmd(evt_pkg::FUNC_ANIMATE, 16'd0, 16'sh7FFF));
        pending_cmds.push_back(make_cmd(evt_pkg::FUNC_TICK, 16'd1, 16'sd0));
        pending_cmds.push_back(make_cmd(evt_pkg::FUNC_TICK, 16'd500, 16'sd0));
        pending_cmds.push_back(make_cmd(evt_pkg::FUNC_TICK, 16'hFFFF, 16'hFFFF));
        pending_cmds.push_back(make_cmd(evt_pkg::FUNC_TICK, 16'd3, 16'sd0));
        pending_cmds.push_back(make_cmd(evt_pkg::FUNC_RESET, 16'hFFFF, 16'sh8000));
        pending_cmds.push_back(make_cmd(evt_pkg::FUNC_RESET, 16'd0, 16'sh8000));
        pending_cmds.push_back(make_cmd(2'd3, 16'hFFFF, 16'hFFFF));
        pending_cmds.push_back(make_cmd(evt_pkg::FUNC_ANIMATE, 16'd0, 16'sh7FFF));
        pending_cmds.push_back(make_cmd(evt_pkg::FUNC_TICK, 16'd999, 16'sd0));
        pending_cmds.push_back(make_cmd(evt_pkg::FUNC_TICK, 16'd1, 16'sd0));
        drain();

        // Phases across mode, duration and delay settings, extremes included
        for (ph = 0; ph < 12; ph++) begin
            write_reg(evt_pkg::CFG_EASING_MODE,
                      (ph < 8) ? 16'(ph) : 16'($urandom_range(0, 7)));
            case (ph % 4)
                0: write_reg(evt_pkg::CFG_DURATION, 16'd0);
                1: write_reg(evt_pkg::CFG_DURATION, 16'hFFFF);
                2: write_reg(evt_pkg::CFG_DURATION, 16'd1);
                default: write_reg(evt_pkg::CFG_DURATION, 16'($urandom_range(2, 3000)));
            endcase
            case (ph % 3)
                0: write_reg(evt_pkg::CFG_DELAY, 16'd0);
                1: write_reg(evt_pkg::CFG_DELAY, 16'hFFFF);
                default: write_reg(evt_pkg::CFG_DELAY, 16'($urandom_range(1, 400)));
            endcase
            random_cmds(78, (ph % 4 == 1) ? 16'hFFFF : 16'($urandom_range(4, 800)));
            if (ph == 5) begin
                // Hold the sender until every result is back
                while (pending_cmds.size() > 40) @(posedge aclk);
                hold_sender = 1;
                while (s_valid || expected_results.size() > 0) @(posedge aclk);
                hold_sender = 0;
            end
            drain();
        end

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
